// File: hw/rtl/dkpc_pkg.sv
// Package for the dispense key press classifier.
// Holds the thresholds, event and tone codes, register indexes and the result record.
// No dependencies.
package dkpc_pkg;

  localparam logic [15:0] SETTLE_TICKS    = 16'd10;
  localparam logic [15:0] SHORT_TICKS     = 16'd80;
  localparam logic [15:0] LONG_TICKS      = 16'd2000;
  localparam logic [15:0] VERY_LONG_TICKS = 16'd8000;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODEL_R_TYPE    = 3'd0,
    REG_TIME_HALF       = 3'd1,
    REG_TIME_ONE        = 3'd2,
    REG_TIME_TWO        = 3'd3,
    REG_TIME_LITER      = 3'd4,
    REG_TIME_CONTINUOUS = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_SHORT      = 3'd1,
    EV_SHORT_TEST = 3'd2,
    EV_LONG       = 3'd3,
    EV_VERY_LONG  = 3'd4
  } key_event_t;

  typedef enum logic [1:0] {
    TONE_NONE       = 2'd0,
    TONE_START      = 2'd1,
    TONE_END        = 2'd2,
    TONE_CONTINUOUS = 2'd3
  } tone_t;

  localparam logic [1:0] CUP_HALF = 2'd0;
  localparam logic [1:0] CUP_ONE  = 2'd1;
  localparam logic [1:0] CUP_TWO  = 2'd2;

  typedef struct packed {
    logic        timer_load;
    tone_t       tone;
    logic [15:0] dispense_time;
    logic        continuous;
    logic        water_out;
    key_event_t  key_event;
  } result_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 16'd1;
  endfunction

endpackage

// File: hw/rtl/dispense_key_press_classifier.sv
// Dispense key press classifier: debounce counters, short/long/very long press
// detection and dispense control. Uses dkpc_pkg.
// Each accepted result is registered into the head entry, or into the skid entry
// while an older one is buffered. Throughput: one request per cycle while the skid
// entry is empty; the two-entry buffer accepts while one waits on out_tready.
// Reset (rst_n, synchronous): key released, counters and flags cleared,
// registers zero.
module dispense_key_press_classifier (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // key_level, test_mode, all_lock, out_disable, cup_level[1:0], zero pad[1:0]
  input  logic [7:0]                    in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // key_event[2:0], water_out, continuous, dispense_time[15:0], tone[1:0], timer_load
  output logic [23:0]                   out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dkpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  import dkpc_pkg::*;

  // configuration
  logic        model_r_type_r;
  logic [15:0] time_half_r, time_one_r, time_two_r, time_liter_r, time_continuous_r;

  // classifier state
  logic        last_level_r, last_level_nxt;
  logic [15:0] stable_ticks_r, stable_ticks_nxt;
  logic [15:0] short_ticks_r, short_ticks_nxt;
  logic [15:0] long_ticks_r, long_ticks_nxt;
  logic        short_done_r, short_done_nxt;
  logic        long_done_r, long_done_nxt;
  logic        very_long_done_r, very_long_done_nxt;
  logic        dispensing_r, dispensing_nxt;
  logic        continuous_on_r, continuous_on_nxt;
  logic [15:0] time_selected_r, time_selected_nxt;

  // result buffer
  result_t     head_r, head_nxt, skid_r, skid_nxt;
  logic        head_valid_r, head_valid_nxt, skid_valid_r, skid_valid_nxt;

  logic        push, pop;
  result_t     res;

  logic        key_level, test_mode, all_lock, out_disable;
  logic [1:0]  cup_level;
  logic [15:0] pick;

  assign key_level   = in_tdata[0];
  assign test_mode   = in_tdata[1];
  assign all_lock    = in_tdata[2];
  assign out_disable = in_tdata[3];
  assign cup_level   = in_tdata[5:4];

  assign cfg_ready  = 1'b1;
  assign in_tready  = !skid_valid_r;
  assign push       = in_tvalid && in_tready;
  assign pop        = head_valid_r && out_tready;
  assign out_tvalid = head_valid_r;
  assign out_tdata  = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_r_type_r    <= 1'b0;
      time_half_r       <= '0;
      time_one_r        <= '0;
      time_two_r        <= '0;
      time_liter_r      <= '0;
      time_continuous_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODEL_R_TYPE:    model_r_type_r    <= cfg_data[0];
        REG_TIME_HALF:       time_half_r       <= cfg_data;
        REG_TIME_ONE:        time_one_r        <= cfg_data;
        REG_TIME_TWO:        time_two_r        <= cfg_data;
        REG_TIME_LITER:      time_liter_r      <= cfg_data;
        REG_TIME_CONTINUOUS: time_continuous_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cup_level)
      CUP_HALF: pick = model_r_type_r ? time_one_r : time_half_r;
      CUP_ONE:  pick = model_r_type_r ? time_two_r : time_one_r;
      CUP_TWO:  pick = model_r_type_r ? time_liter_r : time_two_r;
      default:  pick = time_half_r;
    endcase
  end

  always_comb begin
    last_level_nxt     = last_level_r;
    stable_ticks_nxt   = stable_ticks_r;
    short_ticks_nxt    = short_ticks_r;
    long_ticks_nxt     = long_ticks_r;
    short_done_nxt     = short_done_r;
    long_done_nxt      = long_done_r;
    very_long_done_nxt = very_long_done_r;
    dispensing_nxt     = dispensing_r;
    continuous_on_nxt  = continuous_on_r;
    time_selected_nxt  = time_selected_r;
    res                = '0;
    res.key_event      = EV_NONE;
    res.tone           = TONE_NONE;

    // level tracking
    if (key_level == last_level_r) begin
      if (last_level_r) begin
        stable_ticks_nxt   = '0;
        short_done_nxt     = 1'b0;
        long_done_nxt      = 1'b0;
        very_long_done_nxt = 1'b0;
      end else begin
        stable_ticks_nxt = sat_inc(stable_ticks_r);
      end
      if (stable_ticks_nxt >= SETTLE_TICKS) begin
        short_ticks_nxt = stable_ticks_nxt;
        long_ticks_nxt  = sat_inc(long_ticks_r);
      end
    end else begin
      last_level_nxt   = key_level;
      stable_ticks_nxt = '0;
      short_ticks_nxt  = '0;
      long_ticks_nxt   = '0;
    end

    // classification on the updated counters
    if (!short_done_nxt) begin
      if (short_ticks_nxt >= SHORT_TICKS && short_ticks_nxt < LONG_TICKS) begin
        short_done_nxt  = 1'b1;
        short_ticks_nxt = '0;
        if (test_mode) begin
          res.key_event = EV_SHORT_TEST;
        end else begin
          res.key_event = EV_SHORT;
          if (!all_lock && !out_disable) begin
            if (!dispensing_r) begin
              dispensing_nxt    = 1'b1;
              res.tone          = TONE_START;
              time_selected_nxt = pick;
            end else begin
              dispensing_nxt    = 1'b0;
              continuous_on_nxt = 1'b0;
              res.tone          = TONE_END;
              time_selected_nxt = '0;
            end
          end
        end
      end
    end else if (!long_done_nxt) begin
      if (long_ticks_nxt >= LONG_TICKS) begin
        long_done_nxt = 1'b1;
        res.key_event = EV_LONG;
        if (!test_mode) begin
          if (dispensing_r) begin
            time_selected_nxt = time_continuous_r;
            res.tone          = TONE_CONTINUOUS;
            continuous_on_nxt = 1'b1;
          end else begin
            time_selected_nxt = '0;
          end
        end
      end
    end else if (!very_long_done_nxt) begin
      if (long_ticks_nxt >= VERY_LONG_TICKS) begin
        very_long_done_nxt = 1'b1;
        long_ticks_nxt     = '0;
        res.key_event      = EV_VERY_LONG;
        res.timer_load     = dispensing_r;
      end
    end

    res.water_out     = dispensing_nxt;
    res.continuous    = continuous_on_nxt;
    res.dispense_time = time_selected_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r     <= 1'b1;
      stable_ticks_r   <= '0;
      short_ticks_r    <= '0;
      long_ticks_r     <= '0;
      short_done_r     <= 1'b0;
      long_done_r      <= 1'b0;
      very_long_done_r <= 1'b0;
      dispensing_r     <= 1'b0;
      continuous_on_r  <= 1'b0;
      time_selected_r  <= '0;
    end else if (push) begin
      last_level_r     <= last_level_nxt;
      stable_ticks_r   <= stable_ticks_nxt;
      short_ticks_r    <= short_ticks_nxt;
      long_ticks_r     <= long_ticks_nxt;
      short_done_r     <= short_done_nxt;
      long_done_r      <= long_done_nxt;
      very_long_done_r <= very_long_done_nxt;
      dispensing_r     <= dispensing_nxt;
      continuous_on_r  <= continuous_on_nxt;
      time_selected_r  <= time_selected_nxt;
    end
  end

  // two-entry result buffer: head drives the port, skid catches a push while head stalls
  always_comb begin
    head_nxt       = head_r;
    head_valid_nxt = head_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (pop || !head_valid_r) begin
      if (skid_valid_r) begin
        head_nxt       = skid_r;
        head_valid_nxt = 1'b1;
        skid_nxt       = res;
        skid_valid_nxt = push;
      end else begin
        head_nxt       = res;
        head_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> head_valid_r)
    else $error("skid entry valid without head entry");

  a_cont_needs_disp: assert property (@(posedge clk) disable iff (!rst_n)
    continuous_on_r |-> dispensing_r)
    else $error("continuous dispensing without dispensing");

  a_load_on_very_long: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.timer_load) |-> (res.key_event == EV_VERY_LONG && res.water_out))
    else $error("timer load outside a very long press while dispensing");

  a_count_only_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (stable_ticks_r != 16'd0) |-> !last_level_r)
    else $error("stable count running while key released");

  a_short_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (res.key_event == EV_SHORT || res.key_event == EV_SHORT_TEST)) |=> short_done_r)
    else $error("short press fired without arming its done flag");

endmodule

// File: bench/dispense_key_press_classifier_tb.sv
// Self-checking bench for dispense_key_press_classifier: directed press sequences, then
// random presses, bounces and noise under changing register settings.
// Depends on dkpc_pkg for the register, event and tone codes and the result record.
module dispense_key_press_classifier_tb;
  import dkpc_pkg::*;

  // Tracks the press state and dispense control; holds the results still due.
  class dispense_tracker;
    bit        model_r;
    bit [15:0] t_half, t_one, t_two, t_liter, t_cont;
    bit        last_level;
    bit [15:0] stable, short_cnt, long_cnt;
    bit        short_done, long_done, vlong_done;
    bit        dispensing, cont_on;
    bit [15:0] sel_time;
    result_t   due_results[$];
    int        errors;

    function new();
      last_level = 1'b1;
    endfunction

    function void apply_reg(cfg_reg_t idx, bit [15:0] v);
      case (idx)
        REG_MODEL_R_TYPE:    model_r = v[0];
        REG_TIME_HALF:       t_half = v;
        REG_TIME_ONE:        t_one = v;
        REG_TIME_TWO:        t_two = v;
        REG_TIME_LITER:      t_liter = v;
        REG_TIME_CONTINUOUS: t_cont = v;
        default: ;
      endcase
    endfunction

    function bit [15:0] bump(bit [15:0] v);
      return (v == COUNT_MAX) ? v : v + 16'd1;
    endfunction

    function bit [15:0] cup_time(bit [1:0] cup);
      case (cup)
        CUP_HALF: return model_r ? t_one : t_half;
        CUP_ONE:  return model_r ? t_two : t_one;
        CUP_TWO:  return model_r ? t_liter : t_two;
        default:  return t_half;
      endcase
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void absorb_tick(logic [7:0] d);
      bit      level, test, lock, dis;
      bit [1:0] cup;
      result_t r;
      level = d[0];
      test  = d[1];
      lock  = d[2];
      dis   = d[3];
      cup   = d[5:4];
      r.key_event  = EV_NONE;
      r.tone       = TONE_NONE;
      r.timer_load = 1'b0;
      if (level == last_level) begin
        // steady release rearms all three detections
        if (last_level) begin
          stable = 16'd0;
          short_done = 1'b0;
          long_done = 1'b0;
          vlong_done = 1'b0;
        end else begin
          stable = bump(stable);
        end
        if (stable >= SETTLE_TICKS) begin
          short_cnt = stable;
          long_cnt = bump(long_cnt);
        end
      end else begin
        last_level = level;
        stable = 16'd0;
        short_cnt = 16'd0;
        long_cnt = 16'd0;
      end
      if (!short_done) begin
        if (short_cnt >= SHORT_TICKS && short_cnt < LONG_TICKS) begin
          short_done = 1'b1;
          short_cnt = 16'd0;
          if (test) begin
            r.key_event = EV_SHORT_TEST;
          end else begin
            r.key_event = EV_SHORT;
            if (!lock && !dis) begin
              if (!dispensing) begin
                dispensing = 1'b1;
                r.tone = TONE_START;
                sel_time = cup_time(cup);
              end else begin
                dispensing = 1'b0;
                cont_on = 1'b0;
                r.tone = TONE_END;
                sel_time = 16'd0;
              end
            end
          end
        end
      end else if (!long_done) begin
        if (long_cnt >= LONG_TICKS) begin
          long_done = 1'b1;
          r.key_event = EV_LONG;
          if (!test) begin
            if (dispensing) begin
              sel_time = t_cont;
              r.tone = TONE_CONTINUOUS;
              cont_on = 1'b1;
            end else begin
              sel_time = 16'd0;
            end
          end
        end
      end else if (!vlong_done) begin
        if (long_cnt >= VERY_LONG_TICKS) begin
          vlong_done = 1'b1;
          long_cnt = 16'd0;
          r.key_event = EV_VERY_LONG;
          r.timer_load = dispensing;
        end
      end
      r.water_out = dispensing;
      r.continuous = cont_on;
      r.dispense_time = sel_time;
      due_results.push_back(r);
    endfunction

    function void match_result(logic [23:0] d);
      result_t act, want;
      act = result_t'(d);
      if (due_results.size() == 0) begin
        $error("unexpected result %h", d);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (act.key_event !== want.key_event) begin
        $error("key_event expected %0d actual %0d", want.key_event, act.key_event);
        errors++;
      end
      if (act.water_out !== want.water_out) begin
        $error("water_out expected %0d actual %0d", want.water_out, act.water_out);
        errors++;
      end
      if (act.continuous !== want.continuous) begin
        $error("continuous expected %0d actual %0d", want.continuous, act.continuous);
        errors++;
      end
      if (act.dispense_time !== want.dispense_time) begin
        $error("dispense_time expected %0d actual %0d", want.dispense_time,
               act.dispense_time);
        errors++;
      end
      if (act.tone !== want.tone) begin
        $error("tone expected %0d actual %0d", want.tone, act.tone);
        errors++;
      end
      if (act.timer_load !== want.timer_load) begin
        $error("timer_load expected %0d actual %0d", want.timer_load, act.timer_load);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [23:0]          out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  dispense_tracker tracker;

  bit       idle_on;
  bit       hold_req;
  int       hold_left;
  int       stall_left;
  bit       ctx_test, ctx_lock, ctx_dis, ctx_noise;
  bit [1:0] ctx_cup;

  dispense_key_press_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

  // Result side: check accepted results, then pick out_tready for the next edge.
  always @(posedge clk) begin
    if (out_tvalid && out_tready)
      tracker.match_result(out_tdata);
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 299;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [7:0] tick_word(bit level);
    return {2'b00, ctx_cup, ctx_dis, ctx_lock, ctx_test, level};
  endfunction

  function automatic void randomize_ctx();
    ctx_test = ($urandom_range(0, 5) == 0);
    ctx_lock = ($urandom_range(0, 5) == 0);
    ctx_dis  = ($urandom_range(0, 5) == 0);
    ctx_cup  = 2'($urandom_range(0, 3));
  endfunction

  function automatic void set_ctx(bit test, bit lock, bit dis, bit [1:0] cup);
    ctx_test = test;
    ctx_lock = lock;
    ctx_dis  = dis;
    ctx_cup  = cup;
  endfunction

  task automatic send_tick(input logic [7:0] d);
    int gap;
    if (idle_on && $urandom_range(0, 15) == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    tracker.absorb_tick(d);
  endtask

  task automatic send_level(input bit level, input int n);
    repeat (n) begin
      if (ctx_noise && $urandom_range(0, 31) == 0)
        randomize_ctx();
      send_tick(tick_word(level));
    end
  endtask

  task automatic key_press(input int hold, input int rel);
    send_level(1'b0, hold);
    send_level(1'b1, rel);
  endtask

  // Stop offering requests and wait until every result is back.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input bit model, input bit [15:0] th, input bit [15:0] t1,
                              input bit [15:0] t2, input bit [15:0] tl,
                              input bit [15:0] tc);
    bit [15:0] vals [6];
    cfg_reg_t  idx;
    vals[0] = {15'd0, model};
    vals[1] = th;
    vals[2] = t1;
    vals[3] = t2;
    vals[4] = tl;
    vals[5] = tc;
    idx = REG_MODEL_R_TYPE;
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      tracker.apply_reg(idx, vals[i]);
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_presses(input int count);
    int pick;
    int hold;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // level and controls changing every tick
        repeat ($urandom_range(10, 40)) begin
          randomize_ctx();
          send_tick(tick_word(1'($urandom_range(0, 1))));
        end
      end else begin
        randomize_ctx();
        send_level(1'b1, ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 30));
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            send_level(1'b0, $urandom_range(1, 3));
            send_level(1'b1, $urandom_range(1, 3));
          end
        end
        pick = $urandom_range(0, 99);
        if (pick < 72)
          hold = $urandom_range(60, 400);
        else if (pick < 90)
          hold = $urandom_range(1990, 2300);
        else
          hold = $urandom_range(7990, 8200);
        send_level(1'b0, hold);
      end
    end
  endtask

  initial begin
    int guard;
    tracker = new();
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_index <= REG_MODEL_R_TYPE;
    cfg_data <= 16'h0000;
    out_tready <= 1'b0;
    idle_on = 1'b1;
    ctx_noise = 1'b0;
    set_ctx(1'b0, 1'b0, 1'b0, CUP_HALF);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sequences, smaller cup table.
    write_config(1'b0, 16'd100, 16'd200, 16'd300, 16'd400, 16'd500);
    send_level(1'b1, 5);
    key_press(100, 20);
    key_press(100, 20);
    set_ctx(1'b0, 1'b0, 1'b0, CUP_ONE);
    key_press(90, 20);
    key_press(90, 20);
    set_ctx(1'b0, 1'b0, 1'b0, CUP_TWO);
    key_press(90, 20);
    key_press(90, 20);
    set_ctx(1'b0, 1'b0, 1'b0, 2'd3);
    key_press(90, 20);
    key_press(90, 20);
    set_ctx(1'b1, 1'b0, 1'b0, CUP_HALF);
    key_press(100, 20);
    set_ctx(1'b0, 1'b1, 1'b0, CUP_HALF);
    key_press(100, 20);
    set_ctx(1'b0, 1'b0, 1'b1, CUP_HALF);
    key_press(100, 20);
    // long press while dispensing, then stop
    set_ctx(1'b0, 1'b0, 1'b0, CUP_HALF);
    key_press(2100, 20);
    key_press(100, 20);
    // locked short press leaves dispensing off for the long press
    set_ctx(1'b0, 1'b1, 1'b0, CUP_HALF);
    key_press(2100, 20);
    set_ctx(1'b1, 1'b0, 1'b0, CUP_HALF);
    key_press(2100, 20);
    set_ctx(1'b0, 1'b0, 1'b0, CUP_ONE);
    key_press(8100, 20);
    key_press(100, 20);
    set_ctx(1'b0, 1'b1, 1'b0, CUP_ONE);
    key_press(8100, 20);
    // one-tick release does not rearm the detections
    set_ctx(1'b0, 1'b0, 1'b0, CUP_TWO);
    send_level(1'b0, 100);
    send_level(1'b1, 1);
    send_level(1'b0, 100);
    send_level(1'b1, 20);
    key_press(100, 20);
    // bounce shorter than the settle time
    send_level(1'b0, 3);
    send_level(1'b1, 2);
    send_level(1'b0, 5);
    send_level(1'b1, 1);
    key_press(100, 20);
    key_press(79, 20);
    set_ctx(1'b1, 1'b1, 1'b1, 2'd3);
    send_level(1'b1, 3);
    send_level(1'b0, 2);
    send_level(1'b1, 3);
    wait_idle();

    // Larger cup table with extreme times.
    write_config(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h1234, 16'hFFFF);
    set_ctx(1'b0, 1'b0, 1'b0, CUP_HALF);
    for (int c = 0; c < 4; c++) begin
      ctx_cup = 2'(c);
      key_press(100, 20);
      key_press(100, 20);
    end
    key_press(100, 20);
    // very long press acts normally in test mode
    set_ctx(1'b1, 1'b0, 1'b0, CUP_HALF);
    key_press(8100, 20);
    set_ctx(1'b0, 1'b0, 1'b0, CUP_TWO);
    key_press(100, 20);
    // counters run into saturation
    idle_on = 1'b0;
    key_press(66000, 20);
    idle_on = 1'b1;
    wait_idle();

    // Random presses, a new register setting per phase.
    ctx_noise = 1'b1;
    write_config(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    random_presses(12);
    wait_idle();
    write_config(1'b1, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
    // long receiver hold-off while requests keep coming
    hold_req = 1'b1;
    random_presses(12);
    wait_idle();
    write_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_presses(12);
    wait_idle();
    write_config(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    idle_on = 1'b0;
    random_presses(12);

    in_tvalid <= 1'b0;
    guard = 0;
    while (tracker.pending() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
